/* sv/irbt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the IPv4 range ban table.
package irbt_pkg;

    // Table depth default
    localparam int DEF_MAX_ENTRIES = 64;

    localparam logic [31:0] ALL_ONES_MASK = 32'hFFFF_FFFF;

    // Item modes
    localparam logic [1:0] MODE_LOOKUP    = 2'd0;
    localparam logic [1:0] MODE_ADD_EXACT = 2'd1;
    localparam logic [1:0] MODE_ADD_RANGE = 2'd2;
    localparam logic [1:0] MODE_REMOVE    = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Internal command kinds, produced by the front end
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_PUSH   = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [31:0] range_mask;
    } t_in_item;

    typedef struct packed {
        logic        banned;
        logic [1:0]  status;
        logic [31:0] removed_base;
        logic [31:0] removed_mask;
        logic [6:0]  entry_count;
    } t_out_item;

    // Classified command: lookup address, or base and mask to push
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [31:0] mask;
    } t_cmd;

endpackage

/* sv/irbt_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items, classifies them into commands, queues two.
module irbt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  irbt_pkg::t_in_item i_item,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output irbt_pkg::t_cmd  o_cmd
);
    import irbt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_count;
    t_cmd       cls_cmd;
    logic       wr;
    logic       rd;

    // Classify: mask the base for range adds, full mask for exact adds
    always_comb begin
        cls_cmd.address = i_item.address;
        cls_cmd.mask    = ALL_ONES_MASK;
        case (i_item.mode)
            MODE_LOOKUP: begin
                cls_cmd.op = CMD_LOOKUP;
            end
            MODE_ADD_EXACT: begin
                cls_cmd.op = CMD_PUSH;
            end
            MODE_ADD_RANGE: begin
                cls_cmd.op      = CMD_PUSH;
                cls_cmd.address = i_item.address & i_item.range_mask;
                cls_cmd.mask    = i_item.range_mask;
            end
            default: begin
                cls_cmd.op = CMD_POP;
            end
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign wr          = i_push & ~o_full;
    assign rd          = o_cmd_valid & i_cmd_ready;

    // Queue pointers
    always_comb begin
        n_wp    = wr ? ~r_wp : r_wp;
        n_rp    = rd ? ~r_rp : r_rp;
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 2'd1;
        end else if (rd && !wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cls_cmd;
        end
    end

endmodule

/* sv/irbt_back.sv */
`timescale 1ns / 1ps
// Back end: range store, count, scan sequencer and result queue.
module irbt_back #(
    parameter int MAX_ENTRIES = irbt_pkg::DEF_MAX_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  irbt_pkg::t_cmd     i_cmd,
    output logic               o_empty,
    input  logic               i_pop,
    output irbt_pkg::t_out_item o_item
);
    import irbt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    // Range store
    logic [31:0] r_base_mem [MAX_ENTRIES];
    logic [31:0] r_mask_mem [MAX_ENTRIES];
    logic [31:0] r_rd_base;
    logic [31:0] r_rd_mask;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_filled, n_filled;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_chk, n_chk;
    logic          r_hit, n_hit;
    t_cmd          r_cmd, n_cmd;

    logic          take;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic          hit_now;
    logic          is_full;
    logic [AW-1:0] last_idx;
    logic          res_push;
    t_out_item     res_item;

    // Result queue
    t_out_item r_out_mem [2];
    logic      r_out_wp;
    logic      r_out_rp;
    logic [1:0] r_out_count, n_out_count;
    logic      res_pop;

    assign o_cmd_ready = (r_state == S_IDLE) && (r_out_count != 2'd2);
    assign take        = i_cmd_valid & o_cmd_ready;
    assign is_full     = (r_filled == CW'(MAX_ENTRIES));
    assign last_idx    = AW'(r_filled - 1'b1);
    assign hit_now     = r_chk && ((r_cmd.address & r_rd_mask) == r_rd_base);

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_filled = r_filled;
        n_idx    = r_idx;
        n_chk    = 1'b0;
        n_hit    = r_hit;
        n_cmd    = r_cmd;
        mem_we   = 1'b0;
        mem_wa   = r_filled[AW-1:0];
        mem_re   = 1'b0;
        mem_ra   = r_idx;
        res_push = 1'b0;
        res_item.banned       = 1'b0;
        res_item.status       = STATUS_DONE;
        res_item.removed_base = 32'd0;
        res_item.removed_mask = 32'd0;
        res_item.entry_count  = 7'(r_filled);
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        CMD_LOOKUP: begin
                            if (r_filled == '0) begin
                                res_push = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_hit   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_PUSH: begin
                            res_push = 1'b1;
                            if (is_full) begin
                                res_item.status = STATUS_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                n_filled = r_filled + 1'b1;
                                res_item.entry_count = 7'(n_filled);
                            end
                        end
                        CMD_POP: begin
                            if (r_filled == '0) begin
                                res_push        = 1'b1;
                                res_item.status = STATUS_EMPTY;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = last_idx;
                                n_filled = r_filled - 1'b1;
                                n_state  = S_POP;
                            end
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read one entry a cycle, compare the one read last cycle
                mem_re = 1'b1;
                n_chk  = 1'b1;
                n_hit  = r_hit | hit_now;
                if (r_idx == last_idx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                res_push        = 1'b1;
                res_item.banned = r_hit | hit_now;
                n_state         = S_IDLE;
            end
            S_POP: begin
                res_push              = 1'b1;
                res_item.removed_base = r_rd_base;
                res_item.removed_mask = r_rd_mask;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_filled <= '0;
            r_chk    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_chk    <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        r_cmd <= n_cmd;
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_base_mem[mem_wa] <= i_cmd.address;
            r_mask_mem[mem_wa] <= i_cmd.mask;
        end
        if (mem_re) begin
            r_rd_base <= r_base_mem[mem_ra];
            r_rd_mask <= r_mask_mem[mem_ra];
        end
    end

    // Result queue, two deep
    assign o_empty = (r_out_count == 2'd0);
    assign o_item  = r_out_mem[r_out_rp];
    assign res_pop = i_pop & ~o_empty;

    always_comb begin
        n_out_count = r_out_count;
        if (res_push && !res_pop) begin
            n_out_count = r_out_count + 2'd1;
        end else if (res_pop && !res_push) begin
            n_out_count = r_out_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wp    <= 1'b0;
            r_out_rp    <= 1'b0;
            r_out_count <= 2'd0;
        end else begin
            r_out_wp    <= res_push ? ~r_out_wp : r_out_wp;
            r_out_rp    <= res_pop ? ~r_out_rp : r_out_rp;
            r_out_count <= n_out_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out_mem[r_out_wp] <= res_item;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (r_out_count != 2'd2) || res_pop)
        else $error("result transfer into a full result queue");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_filled != '0))
        else $error("scan on an empty table");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_filled == CW'($past(r_filled) - 1'b1)))
        else $error("remove did not drop the count by one");

endmodule

/* sv/ip_range_ban_table.sv */
`timescale 1ns / 1ps
// Top level of the IPv4 range ban table.
//
// Input side is a queue write port: drive i_in_item and raise push; the
// item transfers at a clock edge where push is high and full is low.
// Result side is a queue read port: while empty is low the oldest result
// sits on o_out_item, and it transfers at an edge where pop is high.
// Every item yields exactly one result, in order.
// Items pass a two-deep command queue into the back end, which handles one
// command at a time. Add and remove-from-empty need no store read there; a
// successful remove needs one store read. A lookup scans the store one
// entry per cycle through its single read port; an empty table is not
// scanned, and the verdict is not banned.
// Results wait in a two-deep result queue; when the receiver stalls the back
// end stops taking commands, the command queue fills and full goes high.
// Reset (synchronous, active low) empties both queues and the table count;
// store contents are not cleared, only counted entries are ever read.
module ip_range_ban_table #(
    parameter int MAX_ENTRIES = irbt_pkg::DEF_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  irbt_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output irbt_pkg::t_out_item o_out_item
);
    import irbt_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    irbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    irbt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

/* sim/irbt_checker.sv */
`timescale 1ns / 1ps
// Checker for the IPv4 range ban table: shadow table, expected-verdict queue and compare.
module irbt_checker #(
    parameter int DEPTH = irbt_pkg::DEF_MAX_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  irbt_pkg::t_in_item  i_in_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  irbt_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import irbt_pkg::*;

    // Shadow copy of the range stack
    logic [31:0] shadow_base [DEPTH];
    logic [31:0] shadow_mask [DEPTH];
    int unsigned shadow_fill = 0;

    t_out_item   verdict_q [$];
    int          mismatch_cnt = 0;
    int          pending_cnt = 0;

    assign o_fail_count = mismatch_cnt;
    assign o_pending    = pending_cnt;

    // Push one range onto the shadow stack, refuse when full
    function automatic logic [1:0] shadow_push(logic [31:0] base, logic [31:0] mask);
        if (shadow_fill >= DEPTH) begin
            return STATUS_FULL;
        end
        shadow_base[shadow_fill] = base;
        shadow_mask[shadow_fill] = mask;
        shadow_fill++;
        return STATUS_DONE;
    endfunction

    // Apply one item to the shadow table and return the verdict it should give
    function automatic t_out_item ban_table_apply(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.mode)
            MODE_LOOKUP: begin
                for (int i = 0; i < shadow_fill; i++) begin
                    if ((it.address & shadow_mask[i]) == shadow_base[i]) begin
                        r.banned = 1'b1;
                    end
                end
            end
            MODE_ADD_EXACT: begin
                r.status = shadow_push(it.address, ALL_ONES_MASK);
            end
            MODE_ADD_RANGE: begin
                r.status = shadow_push(it.address & it.range_mask, it.range_mask);
            end
            default: begin
                if (shadow_fill == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    shadow_fill--;
                    r.removed_base = shadow_base[shadow_fill];
                    r.removed_mask = shadow_mask[shadow_fill];
                end
            end
        endcase
        r.entry_count = shadow_fill[6:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_v, got_v);
            mismatch_cnt++;
        end
    endtask

    // Result side first, then the new transfer on the item side
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (!i_rst_n) begin
            shadow_fill = 0;
            verdict_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_out_item);
                    mismatch_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("banned", 32'(want.banned), 32'(i_out_item.banned));
                    check_field("status", 32'(want.status), 32'(i_out_item.status));
                    check_field("removed_base", want.removed_base, i_out_item.removed_base);
                    check_field("removed_mask", want.removed_mask, i_out_item.removed_mask);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_out_item.entry_count));
                end
            end
            if (i_push && !i_full) begin
                pred = ban_table_apply(i_in_item);
                verdict_q.insert(verdict_q.size(), pred);
            end
        end
        pending_cnt = verdict_q.size();
    end

endmodule

/* sim/tb_ip_range_ban_table.sv */
`timescale 1ns / 1ps
// Testbench top for the IPv4 range ban table: clock, reset, stimulus and verdict.
module tb_ip_range_ban_table;
    import irbt_pkg::*;

    localparam int TBL_DEPTH   = DEF_MAX_ENTRIES;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 100;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_in_item;
    logic      empty;
    logic      pop;
    t_out_item o_out_item;

    int        fail_count;
    int        pending;
    int        cycle_cnt;

    // Stimulus shaping
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      stall_req;
    int        tbl_level;
    int        sent_cnt;
    logic [31:0] added_addr [$];

    ip_range_ban_table #(
        .MAX_ENTRIES(TBL_DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item)
    );

    irbt_checker #(
        .DEPTH(TBL_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in_item   (i_in_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_item  (o_out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ip_range_ban_table test failed");
            $finish;
        end
    end

    // Receiver: random pop, plus one long hold-off on request
    initial begin
        int hold_left;
        logic stall_taken;
        hold_left = 0;
        stall_taken = 1'b0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req && !stall_taken) begin
                hold_left = HOLD_CYCLES;
                stall_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One item transfer; entered and left at a falling edge
    task automatic send(logic [1:0] m, logic [31:0] a, logic [31:0] k);
        t_in_item it;
        it.mode       = m;
        it.address    = a;
        it.range_mask = k;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        sent_cnt++;
        // Track the fill level only to steer later bursts
        if ((m == MODE_ADD_EXACT || m == MODE_ADD_RANGE) && tbl_level < TBL_DEPTH) begin
            tbl_level++;
            added_addr.insert(added_addr.size(), a);
        end else if (m == MODE_REMOVE && tbl_level > 0) begin
            tbl_level--;
            added_addr.delete(added_addr.size() - 1);
        end
    endtask

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(15))
            0:       return 32'h0;
            1:       return ALL_ONES_MASK;
            2, 3, 4: return $urandom;
            default: return ALL_ONES_MASK << (32 - $urandom_range(1, 31));
        endcase
    endfunction

    // Lookup address: often one that was added (hit), sometimes nudged or random
    function automatic logic [31:0] lookup_addr();
        logic [31:0] a;
        if (added_addr.size() > 0 && $urandom_range(1)) begin
            a = added_addr[$urandom_range(added_addr.size() - 1)];
            if ($urandom_range(1)) begin
                a[7:0] = 8'($urandom);
            end
            return a;
        end
        return $urandom;
    endfunction

    task automatic send_add();
        if ($urandom_range(1)) begin
            send(MODE_ADD_EXACT, $urandom, $urandom);
        end else begin
            send(MODE_ADD_RANGE, $urandom, rand_mask());
        end
    endtask

    // Random part: fill, drain and mixed bursts
    task automatic run_bursts(int n_items);
        int stop_at;
        int kind;
        int n;
        stop_at = sent_cnt + n_items;
        kind = 0;
        while (sent_cnt < stop_at) begin
            case (kind)
                0: begin
                    while (tbl_level < TBL_DEPTH) begin
                        if ($urandom_range(4) == 0) send(MODE_LOOKUP, lookup_addr(), $urandom);
                        else send_add();
                    end
                    repeat ($urandom_range(1, 4)) send_add();
                    repeat ($urandom_range(1, 3)) send(MODE_LOOKUP, lookup_addr(), $urandom);
                end
                1: begin
                    while (tbl_level > 0) begin
                        if ($urandom_range(4) == 0) send(MODE_LOOKUP, lookup_addr(), $urandom);
                        else send(MODE_REMOVE, $urandom, $urandom);
                    end
                    repeat ($urandom_range(1, 3)) send(MODE_REMOVE, $urandom, $urandom);
                    send(MODE_LOOKUP, $urandom, $urandom);
                end
                default: begin
                    n = $urandom_range(10, 40);
                    repeat (n) begin
                        case ($urandom_range(3))
                            0:       send(MODE_LOOKUP, lookup_addr(), $urandom);
                            1, 2:    send_add();
                            default: send(MODE_REMOVE, $urandom, $urandom);
                        endcase
                    end
                end
            endcase
            case ($urandom_range(5))
                0:       kind = 0;
                1:       kind = 1;
                default: kind = 2;
            endcase
        end
    endtask

    // Main stimulus and verdict
    initial begin
        int waited;
        push          = 1'b0;
        i_in_item     = '0;
        i_rst_n       = 1'b0;
        stall_req     = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 49;
        tbl_level     = 0;
        sent_cnt      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, extremes, prefix and odd masks, zero mask
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_ADD_EXACT, 32'h0, 32'hFFFF_FFFF);
        send(MODE_ADD_EXACT, 32'hFFFF_FFFF, 32'h0);
        send(MODE_LOOKUP, 32'h0, 32'h0);
        send(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send(MODE_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF);
        send(MODE_ADD_RANGE, 32'h0A01_0203, 32'hFF00_0000);
        send(MODE_LOOKUP, 32'h0AC8_0101, 32'h0);
        send(MODE_LOOKUP, 32'h0B00_0001, 32'h0);
        send(MODE_ADD_RANGE, 32'hC0A8_0155, 32'hFFFF_0F00);
        send(MODE_LOOKUP, 32'hC0A8_F1AA, 32'h0);
        send(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_ADD_RANGE, 32'hDEAD_BEEF, 32'h0);
        send(MODE_LOOKUP, 32'h5A5A_A5A5, 32'h0);
        send(MODE_REMOVE, 32'h0, 32'h0);
        send(MODE_ADD_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(MODE_LOOKUP, 32'hFFFF_FFFE, 32'h0);
        send(MODE_REMOVE, 32'h0, 32'h0);

        run_bursts(430);

        send_idle_pct = 49;
        recv_idle_pct = 10;
        run_bursts(430);

        // No idling; receiver holds off for a while so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req = 1'b1;
        run_bursts(430);

        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        waited = 0;
        while (waited < DRAIN_WAIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (fail_count == 0) begin
            $display("ip_range_ban_table test passed");
        end else begin
            $display("ip_range_ban_table test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/irbt_pkg.sv
sv/irbt_front.sv
sv/irbt_back.sv
sv/ip_range_ban_table.sv
sim/irbt_checker.sv
sim/tb_ip_range_ban_table.sv
